FILE: src/path_containment_checker_unit_assert.svh
// assertion macros for the path containment checker
`ifndef PATH_CONTAINMENT_CHECKER_UNIT_ASSERT_SVH
`define PATH_CONTAINMENT_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PCC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pcc assertion failed");
`define PCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define PCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/pcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

  localparam int unsigned ROOT_SEGMENTS   = 64;
  localparam int unsigned JOINED_SEGMENTS = 256;
  localparam int unsigned JOINED_CHARS    = 8192;
  localparam int unsigned ROOT_CHARS      = 1024;

  localparam int unsigned RootIdxW  = $clog2(ROOT_SEGMENTS);
  localparam int unsigned RootCntW  = $clog2(ROOT_SEGMENTS + 1);
  localparam int unsigned RootAddrW = $clog2(ROOT_CHARS);
  localparam int unsigned RootLenW  = $clog2(ROOT_CHARS + 1);
  localparam int unsigned JoinIdxW  = $clog2(JOINED_SEGMENTS);
  localparam int unsigned JoinCntW  = $clog2(JOINED_SEGMENTS + 1);
  localparam int unsigned JoinAddrW = $clog2(JOINED_CHARS);
  localparam int unsigned JoinLenW  = $clog2(JOINED_CHARS);

  localparam logic [1:0] MODE_ROOT = 2'd0;
  localparam logic [1:0] MODE_DIR  = 2'd1;
  localparam logic [1:0] MODE_TGT  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    ROP_NONE  = 2'd0,
    ROP_BYTE  = 2'd1,
    ROP_CLEAR = 2'd2
  } root_op_e;

  typedef enum logic [1:0] {
    JOP_NONE  = 2'd0,
    JOP_FEED  = 2'd1,
    JOP_CLOSE = 2'd2,
    JOP_CLEAR = 2'd3
  } join_op_e;

  typedef struct packed {
    root_op_e   op;
    logic [7:0] ch;
  } root_req_t;

  typedef struct packed {
    join_op_e   op;
    logic [7:0] ch;
  } join_req_t;

  typedef struct packed {
    logic [RootCntW-1:0] cnt;
    logic                bad;
  } root_stat_t;

  typedef struct packed {
    logic [JoinCntW-1:0]  cnt;
    logic [JoinAddrW-1:0] tot;
    logic [7:0]           last;
    logic                 bad;
  } join_stat_t;

  typedef struct packed {
    logic [RootAddrW-1:0] start;
    logic [RootLenW-1:0]  len;
  } root_seg_t;

  typedef struct packed {
    logic [JoinAddrW-1:0] start;
    logic [JoinLenW-1:0]  len;
  } join_seg_t;

endpackage
`default_nettype wire

FILE: src/pcc_root_store.sv
`timescale 1ns / 1ps
`default_nettype none
module pcc_root_store (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  pcc_pkg::root_req_t                req_i,
  input  wire  [pcc_pkg::RootIdxW-1:0]      seg_idx_i,
  input  wire  [pcc_pkg::RootAddrW-1:0]     byte_addr_i,
  output pcc_pkg::root_stat_t               stat_o,
  output pcc_pkg::root_seg_t                seg_o,
  output logic [7:0]                        byte_o
);

  logic [pcc_pkg::RootLenW-1:0] fill_q, fill_d, cur_len_q, cur_len_d, st_full;
  logic [pcc_pkg::RootCntW-1:0] cnt_q, cnt_d;
  logic [7:0] c0_q, c0_d, c1_q, c1_d;
  logic done_q, done_d, bad_q, bad_d;
  logic close, seg_we, byte_we, dot1, dot2;
  pcc_pkg::root_seg_t seg_wr;
  pcc_pkg::root_seg_t seg_mem [pcc_pkg::ROOT_SEGMENTS];
  logic [7:0] byte_mem [pcc_pkg::ROOT_CHARS];

  always_comb begin
    fill_d    = fill_q;
    cur_len_d = cur_len_q;
    cnt_d     = cnt_q;
    c0_d      = c0_q;
    c1_d      = c1_q;
    done_d    = done_q;
    bad_d     = bad_q;
    close     = 1'b0;
    seg_we    = 1'b0;
    byte_we   = 1'b0;
    st_full   = fill_q - cur_len_q;
    seg_wr.start = st_full[pcc_pkg::RootAddrW-1:0];
    seg_wr.len   = cur_len_q;
    dot1 = (cur_len_q == pcc_pkg::RootLenW'(1)) && (c0_q == pcc_pkg::CH_DOT);
    dot2 = (cur_len_q == pcc_pkg::RootLenW'(2)) && (c0_q == pcc_pkg::CH_DOT)
           && (c1_q == pcc_pkg::CH_DOT);
    unique case (req_i.op)
      pcc_pkg::ROP_BYTE: begin
        if (!done_q) begin
          if (req_i.ch == pcc_pkg::CH_NUL) begin
            close  = 1'b1;
            done_d = 1'b1;
          end else if (fill_q >= pcc_pkg::RootLenW'(pcc_pkg::ROOT_CHARS)) begin
            bad_d = 1'b1;
          end else begin
            if (req_i.ch == pcc_pkg::CH_SLASH) begin
              close = 1'b1;
            end else begin
              cur_len_d = cur_len_q + pcc_pkg::RootLenW'(1);
              if (cur_len_q == '0) c0_d = req_i.ch;
              if (cur_len_q == pcc_pkg::RootLenW'(1)) c1_d = req_i.ch;
            end
            byte_we = 1'b1;
            fill_d  = fill_q + pcc_pkg::RootLenW'(1);
          end
        end
      end
      pcc_pkg::ROP_CLEAR: begin
        fill_d    = '0;
        cur_len_d = '0;
        cnt_d     = '0;
        done_d    = 1'b0;
        bad_d     = 1'b0;
      end
      default: ;
    endcase
    if (close) begin
      cur_len_d = '0;
      priority if (cur_len_q == '0) begin
      end else if (dot1) begin
      end else if (dot2) begin
        if (cnt_q != '0) cnt_d = cnt_q - pcc_pkg::RootCntW'(1);
      end else if (cnt_q == pcc_pkg::RootCntW'(pcc_pkg::ROOT_SEGMENTS)) begin
        bad_d = 1'b1;
      end else begin
        seg_we = 1'b1;
        cnt_d  = cnt_q + pcc_pkg::RootCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      cur_len_q <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      bad_q     <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      cur_len_q <= cur_len_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      bad_q     <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q <= c0_d;
    c1_q <= c1_d;
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[cnt_q[pcc_pkg::RootIdxW-1:0]] <= seg_wr;
    seg_o <= seg_mem[seg_idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[fill_q[pcc_pkg::RootAddrW-1:0]] <= req_i.ch;
    byte_o <= byte_mem[byte_addr_i];
  end

  assign stat_o.cnt = cnt_q;
  assign stat_o.bad = bad_q;

endmodule
`default_nettype wire

FILE: src/pcc_join_store.sv
`timescale 1ns / 1ps
`default_nettype none
module pcc_join_store (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  pcc_pkg::join_req_t                req_i,
  input  wire  [pcc_pkg::JoinIdxW-1:0]      seg_idx_i,
  input  wire  [pcc_pkg::JoinAddrW-1:0]     byte_addr_i,
  output pcc_pkg::join_stat_t               stat_o,
  output pcc_pkg::join_seg_t                seg_o,
  output logic [7:0]                        byte_o
);

  logic [pcc_pkg::JoinAddrW-1:0] tot_q, tot_d;
  logic [pcc_pkg::JoinLenW-1:0]  cur_len_q, cur_len_d;
  logic [pcc_pkg::JoinCntW-1:0]  cnt_q, cnt_d;
  logic [7:0] c0_q, c0_d, c1_q, c1_d, last_q, last_d;
  logic bad_q, bad_d;
  logic close, seg_we, byte_we, dot1, dot2;
  pcc_pkg::join_seg_t seg_wr;
  pcc_pkg::join_seg_t seg_mem [pcc_pkg::JOINED_SEGMENTS];
  logic [7:0] byte_mem [pcc_pkg::JOINED_CHARS];

  always_comb begin
    tot_d     = tot_q;
    cur_len_d = cur_len_q;
    cnt_d     = cnt_q;
    c0_d      = c0_q;
    c1_d      = c1_q;
    last_d    = last_q;
    bad_d     = bad_q;
    close     = 1'b0;
    seg_we    = 1'b0;
    byte_we   = 1'b0;
    seg_wr.start = tot_q - pcc_pkg::JoinAddrW'(cur_len_q);
    seg_wr.len   = cur_len_q;
    dot1 = (cur_len_q == pcc_pkg::JoinLenW'(1)) && (c0_q == pcc_pkg::CH_DOT);
    dot2 = (cur_len_q == pcc_pkg::JoinLenW'(2)) && (c0_q == pcc_pkg::CH_DOT)
           && (c1_q == pcc_pkg::CH_DOT);
    unique case (req_i.op)
      pcc_pkg::JOP_FEED: begin
        if (tot_q != pcc_pkg::JoinAddrW'(pcc_pkg::JOINED_CHARS - 1)) begin
          if (req_i.ch == pcc_pkg::CH_SLASH) begin
            close = 1'b1;
          end else begin
            cur_len_d = cur_len_q + pcc_pkg::JoinLenW'(1);
            if (cur_len_q == '0) c0_d = req_i.ch;
            if (cur_len_q == pcc_pkg::JoinLenW'(1)) c1_d = req_i.ch;
          end
          byte_we = 1'b1;
          last_d  = req_i.ch;
          tot_d   = tot_q + pcc_pkg::JoinAddrW'(1);
        end
      end
      pcc_pkg::JOP_CLOSE: close = 1'b1;
      pcc_pkg::JOP_CLEAR: begin
        tot_d     = '0;
        cur_len_d = '0;
        cnt_d     = '0;
        bad_d     = 1'b0;
      end
      default: ;
    endcase
    if (close) begin
      cur_len_d = '0;
      priority if (cur_len_q == '0) begin
      end else if (dot1) begin
      end else if (dot2) begin
        if (cnt_q != '0) cnt_d = cnt_q - pcc_pkg::JoinCntW'(1);
      end else if (cnt_q == pcc_pkg::JoinCntW'(pcc_pkg::JOINED_SEGMENTS)) begin
        bad_d = 1'b1;
      end else begin
        seg_we = 1'b1;
        cnt_d  = cnt_q + pcc_pkg::JoinCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q     <= '0;
      cur_len_q <= '0;
      cnt_q     <= '0;
      bad_q     <= 1'b0;
    end else begin
      tot_q     <= tot_d;
      cur_len_q <= cur_len_d;
      cnt_q     <= cnt_d;
      bad_q     <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[cnt_q[pcc_pkg::JoinIdxW-1:0]] <= seg_wr;
    seg_o <= seg_mem[seg_idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[tot_q] <= req_i.ch;
    byte_o <= byte_mem[byte_addr_i];
  end

  assign stat_o.cnt  = cnt_q;
  assign stat_o.tot  = tot_q;
  assign stat_o.last = last_q;
  assign stat_o.bad  = bad_q;

endmodule
`default_nettype wire

FILE: src/path_containment_checker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                     | handshake
// ----------+---------------------------+------------------------------------
// input     | mode_i, char_code_i       | transfer when start && !busy
// result    | verdict_o                 | valid_o high for one cycle
//
// root and directory bytes, and target bytes other than the terminator, are taken without raising busy
// a target byte that first needs the directory slash passes through S_SLASH before it is fed
// the target terminator runs S_CLOSE and S_CHECK, then walks the root segments with the one shared
// byte comparator (S_SEGRD and S_SEGCMP per segment, S_BYTERD and S_BYTECMP per byte), after S_SLASH
// when the directory slash is still due; an early unsafe finding ends the walk sooner
// reset is asynchronous and active low; no memory clearing pass is needed
// the result cannot be stalled; busy stays high through the verdict cycle
module path_containment_checker_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  output logic       busy,
  input  wire  [1:0] mode_i,
  input  wire  [7:0] char_code_i,
  output logic       valid_o,
  output logic       verdict_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SLASH   = 9'b000000010,
    S_CLOSE   = 9'b000000100,
    S_CHECK   = 9'b000001000,
    S_SEGRD   = 9'b000010000,
    S_SEGCMP  = 9'b000100000,
    S_BYTERD  = 9'b001000000,
    S_BYTECMP = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] ch_q, ch_d, tgt_c;
  logic dir_done_q, dir_done_d, started_q, started_d, tgt_bad_q, tgt_bad_d;
  logic verdict_q, verdict_d, accept, need_slash, tgt_do, fail_fast;
  logic [pcc_pkg::RootIdxW-1:0]  idx_q, idx_d;
  logic [pcc_pkg::RootLenW-1:0]  k_q, k_d, len_q, len_d;
  logic [pcc_pkg::RootAddrW-1:0] rs_q, rs_d;
  logic [pcc_pkg::JoinAddrW-1:0] js_q, js_d;

  pcc_pkg::root_req_t  root_req;
  pcc_pkg::join_req_t  join_req;
  pcc_pkg::root_stat_t root_stat;
  pcc_pkg::join_stat_t join_stat;
  pcc_pkg::root_seg_t  root_seg;
  pcc_pkg::join_seg_t  join_seg;
  logic [7:0] root_byte, join_byte;

  pcc_root_store u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (root_req),
    .seg_idx_i   (idx_q),
    .byte_addr_i (rs_q + k_q[pcc_pkg::RootAddrW-1:0]),
    .stat_o      (root_stat),
    .seg_o       (root_seg),
    .byte_o      (root_byte)
  );

  pcc_join_store u_join (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (join_req),
    .seg_idx_i   (pcc_pkg::JoinIdxW'(idx_q)),
    .byte_addr_i (js_q + pcc_pkg::JoinAddrW'(k_q)),
    .stat_o      (join_stat),
    .seg_o       (join_seg),
    .byte_o      (join_byte)
  );

  assign accept     = start && (state_q == S_IDLE);
  assign need_slash = !dir_done_q && (join_stat.tot != '0)
                      && (join_stat.last != pcc_pkg::CH_SLASH);
  assign fail_fast  = !started_q || root_stat.bad || join_stat.bad || tgt_bad_q
      || (join_stat.tot == pcc_pkg::JoinAddrW'(pcc_pkg::JOINED_CHARS - 1))
      || (root_stat.cnt == pcc_pkg::RootCntW'(pcc_pkg::ROOT_SEGMENTS))
      || (join_stat.cnt == pcc_pkg::JoinCntW'(pcc_pkg::JOINED_SEGMENTS))
      || (16'(join_stat.cnt) < 16'(root_stat.cnt));

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    dir_done_d = dir_done_q;
    started_d  = started_q;
    tgt_bad_d  = tgt_bad_q;
    verdict_d  = verdict_q;
    idx_d      = idx_q;
    k_d        = k_q;
    len_d      = len_q;
    rs_d       = rs_q;
    js_d       = js_q;
    tgt_do     = 1'b0;
    tgt_c      = char_code_i;
    root_req   = '{op: pcc_pkg::ROP_NONE, ch: char_code_i};
    join_req   = '{op: pcc_pkg::JOP_NONE, ch: char_code_i};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            pcc_pkg::MODE_ROOT: root_req.op = pcc_pkg::ROP_BYTE;
            pcc_pkg::MODE_DIR: begin
              if (!dir_done_q) begin
                if (char_code_i == pcc_pkg::CH_NUL) begin
                  dir_done_d = 1'b1;
                  if (need_slash) join_req = '{op: pcc_pkg::JOP_FEED, ch: pcc_pkg::CH_SLASH};
                end else begin
                  join_req.op = pcc_pkg::JOP_FEED;
                end
              end
            end
            pcc_pkg::MODE_TGT: begin
              dir_done_d = 1'b1;
              if (need_slash) begin
                join_req = '{op: pcc_pkg::JOP_FEED, ch: pcc_pkg::CH_SLASH};
                ch_d     = char_code_i;
                state_d  = S_SLASH;
              end else begin
                tgt_do = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SLASH: begin
        tgt_do = 1'b1;
        tgt_c  = ch_q;
      end
      S_CLOSE: begin
        root_req = '{op: pcc_pkg::ROP_BYTE, ch: pcc_pkg::CH_NUL};
        join_req = '{op: pcc_pkg::JOP_CLOSE, ch: pcc_pkg::CH_NUL};
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        idx_d = '0;
        priority if (fail_fast) begin
          verdict_d = 1'b0;
          state_d   = S_FIN;
        end else if (root_stat.cnt == '0) begin
          verdict_d = 1'b1;
          state_d   = S_FIN;
        end else begin
          state_d = S_SEGRD;
        end
      end
      S_SEGRD: state_d = S_SEGCMP;
      S_SEGCMP: begin
        if (16'(join_seg.len) != 16'(root_seg.len)) begin
          verdict_d = 1'b0;
          state_d   = S_FIN;
        end else begin
          rs_d    = root_seg.start;
          js_d    = join_seg.start;
          len_d   = root_seg.len;
          k_d     = '0;
          state_d = S_BYTERD;
        end
      end
      S_BYTERD: state_d = S_BYTECMP;
      S_BYTECMP: begin
        priority if (root_byte != join_byte) begin
          verdict_d = 1'b0;
          state_d   = S_FIN;
        end else if (k_q + pcc_pkg::RootLenW'(1) == len_q) begin
          if (16'(idx_q) + 16'd1 == 16'(root_stat.cnt)) begin
            verdict_d = 1'b1;
            state_d   = S_FIN;
          end else begin
            idx_d   = idx_q + pcc_pkg::RootIdxW'(1);
            state_d = S_SEGRD;
          end
        end else begin
          k_d     = k_q + pcc_pkg::RootLenW'(1);
          state_d = S_BYTERD;
        end
      end
      S_FIN: begin
        root_req.op = pcc_pkg::ROP_CLEAR;
        join_req.op = pcc_pkg::JOP_CLEAR;
        dir_done_d  = 1'b0;
        started_d   = 1'b0;
        tgt_bad_d   = 1'b0;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (tgt_do) begin
      if (tgt_c != pcc_pkg::CH_NUL) begin
        if (!started_q) begin
          started_d = 1'b1;
          if (tgt_c == pcc_pkg::CH_SLASH) tgt_bad_d = 1'b1;
        end
        join_req = '{op: pcc_pkg::JOP_FEED, ch: tgt_c};
        state_d  = S_IDLE;
      end else begin
        state_d = S_CLOSE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dir_done_q <= 1'b0;
      started_q  <= 1'b0;
      tgt_bad_q  <= 1'b0;
      idx_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      dir_done_q <= dir_done_d;
      started_q  <= started_d;
      tgt_bad_q  <= tgt_bad_d;
      idx_q      <= idx_d;
      k_q        <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    verdict_q <= verdict_d;
    len_q     <= len_d;
    rs_q      <= rs_d;
    js_q      <= js_d;
  end

  assign busy      = (state_q != S_IDLE);
  assign valid_o   = (state_q == S_FIN);
  assign verdict_o = verdict_q;

`include "path_containment_checker_unit_assert.svh"

  `PCC_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, valid_o, !valid_o)
  `PCC_ASSERT_NEXT(a_short_modes_free, clk_i, rst_ni, accept && (mode_i != pcc_pkg::MODE_TGT), !busy)
  `PCC_ASSERT_NEXT(a_cleared_after, clk_i, rst_ni, valid_o, (root_stat.cnt == '0) && (join_stat.tot == '0) && !started_q)
  `PCC_ASSERT_IMPLIES(a_verdict_started, clk_i, rst_ni, valid_o && verdict_o, started_q && !tgt_bad_q)

endmodule
`default_nettype wire

FILE: tb/sv/path_containment_checker_unit_tb.sv
`timescale 1ns / 1ps
module path_containment_checker_unit_tb;
  import pcc_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic [1:0] mode_i = MODE_ROOT;
  logic [7:0] char_code_i = CH_NUL;
  wire        busy;
  wire        valid_o;
  wire        verdict_o;

  path_containment_checker_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .mode_i(mode_i), .char_code_i(char_code_i),
    .valid_o(valid_o), .verdict_o(verdict_o)
  );

  always #6 clk_i = ~clk_i;

  localparam logic [5:0] F_ROOT_DONE = 6'd1;
  localparam logic [5:0] F_DIR_DONE  = 6'd2;
  localparam logic [5:0] F_TGT_SEEN  = 6'd4;
  localparam logic [5:0] F_ROOT_BAD  = 6'd8;
  localparam logic [5:0] F_JOIN_BAD  = 6'd16;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // shadow copy of the path state
  logic [7:0]  rt_byte [ROOT_CHARS];
  int unsigned rt_st [ROOT_SEGMENTS];
  int unsigned rt_len [ROOT_SEGMENTS];
  int unsigned rt_cnt, rt_fill, rt_open;
  logic [7:0]  jn_byte [JOINED_CHARS];
  int unsigned jn_st [JOINED_SEGMENTS];
  int unsigned jn_len [JOINED_SEGMENTS];
  int unsigned jn_cnt, jn_tot, jn_open;
  logic [5:0]  flags;

  bit          verdicts_due [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  bit          idling_on = 1'b1;

  function automatic void clear_paths();
    rt_cnt = 0; rt_fill = 0; rt_open = 0;
    jn_cnt = 0; jn_tot = 0; jn_open = 0;
    flags = '0;
  endfunction

  function automatic void close_root_seg();
    int unsigned len, st;
    len = rt_open;
    st = rt_fill - len;
    rt_open = 0;
    if (len == 0) return;
    if (len == 1 && rt_byte[st] == CH_DOT) return;
    if (len == 2 && rt_byte[st] == CH_DOT && rt_byte[st+1] == CH_DOT) begin
      if (rt_cnt > 0) rt_cnt--;
      return;
    end
    if (rt_cnt >= ROOT_SEGMENTS) begin
      flags |= F_ROOT_BAD;
      return;
    end
    rt_st[rt_cnt] = st;
    rt_len[rt_cnt] = len;
    rt_cnt++;
  endfunction

  function automatic void close_join_seg();
    int unsigned len, st;
    len = jn_open;
    st = jn_tot - len;
    jn_open = 0;
    if (len == 0) return;
    if (len == 1 && jn_byte[st] == CH_DOT) return;
    if (len == 2 && jn_byte[st] == CH_DOT && jn_byte[st+1] == CH_DOT) begin
      if (jn_cnt > 0) jn_cnt--;
      return;
    end
    if (jn_cnt >= JOINED_SEGMENTS) begin
      flags |= F_JOIN_BAD;
      return;
    end
    jn_st[jn_cnt] = st;
    jn_len[jn_cnt] = len;
    jn_cnt++;
  endfunction

  function automatic void join_push(logic [7:0] c);
    if (jn_tot >= JOINED_CHARS - 1) return;
    if (c == CH_SLASH) close_join_seg();
    else jn_open++;
    jn_byte[jn_tot] = c;
    jn_tot++;
  endfunction

  function automatic void close_dir();
    if (flags & F_DIR_DONE) return;
    flags |= F_DIR_DONE;
    if (jn_tot > 0 && jn_byte[jn_tot-1] != CH_SLASH) join_push(CH_SLASH);
  endfunction

  function automatic bit containment();
    if (!(flags & F_ROOT_DONE)) close_root_seg();
    close_join_seg();
    if (!(flags & F_TGT_SEEN)) return 1'b0;
    if (flags & (F_ROOT_BAD | F_JOIN_BAD)) return 1'b0;
    if (jn_tot == JOINED_CHARS - 1) return 1'b0;
    if (rt_cnt == ROOT_SEGMENTS || jn_cnt == JOINED_SEGMENTS) return 1'b0;
    if (jn_cnt < rt_cnt) return 1'b0;
    for (int unsigned i = 0; i < rt_cnt; i++) begin
      if (jn_len[i] != rt_len[i]) return 1'b0;
      for (int unsigned k = 0; k < rt_len[i]; k++)
        if (jn_byte[jn_st[i]+k] != rt_byte[rt_st[i]+k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_byte(logic [1:0] m, logic [7:0] c);
    if (m == MODE_ROOT) begin
      if (flags & F_ROOT_DONE) return;
      if (c == CH_NUL) begin
        close_root_seg();
        flags |= F_ROOT_DONE;
      end else if (rt_fill >= ROOT_CHARS) begin
        flags |= F_ROOT_BAD;
      end else begin
        if (c == CH_SLASH) close_root_seg();
        else rt_open++;
        rt_byte[rt_fill] = c;
        rt_fill++;
      end
    end else if (m == MODE_DIR) begin
      if (flags & F_DIR_DONE) return;
      if (c == CH_NUL) close_dir();
      else join_push(c);
    end else if (m == MODE_TGT) begin
      close_dir();
      if (c != CH_NUL) begin
        if (!(flags & F_TGT_SEEN)) begin
          flags |= F_TGT_SEEN;
          if (c == CH_SLASH) flags |= F_JOIN_BAD;
        end
        join_push(c);
      end else begin
        verdicts_due.push_back(containment());
        clear_paths();
      end
    end
  endfunction

  // called at a falling edge, returns at a falling edge with start still high
  task automatic send_byte(logic [1:0] m, logic [7:0] c);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    start = 1'b1;
    mode_i = m;
    char_code_i = c;
    do @(posedge clk_i); while (busy);
    predict_byte(m, c);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_str(logic [1:0] m, string s, bit term = 1'b1);
    for (int i = 0; i < s.len(); i++) send_byte(m, s[i]);
    if (term) send_byte(m, CH_NUL);
  endtask

  task automatic send_triple(string r, string d, string t);
    send_str(MODE_ROOT, r);
    send_str(MODE_DIR, d);
    send_str(MODE_TGT, t);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual %0b", $time, verdict_o);
        errors++;
      end else begin
        bit want;
        want = verdicts_due.pop_front();
        if (verdict_o !== want) begin
          $display("%0t: verdict mismatch, expected %0b, actual %0b", $time, want,
                   verdict_o);
          errors++;
        end
      end
    end
  end

  task automatic test_basic();
    send_triple("/srv/www", "/srv/www/a", "b");
    send_triple("/srv/www", "/srv/www", "../etc");
    send_triple("/a", "/a/", "");
    send_triple("/a", "/a", "/a/b");
    send_triple("/a/./b/", "//a//b/.", "./c/..");
    send_triple("", "", "x");
    send_triple("/..", "..", "..");
    send_triple("/a", "/a", "\xff\x01");
  endtask

  task automatic test_odd_order();
    send_byte(MODE_NONE, 8'hFF);
    send_str(MODE_ROOT, "/q");
    send_str(MODE_ROOT, "zz");
    send_str(MODE_DIR, "/q", 1'b0);
    send_byte(MODE_NONE, CH_SLASH);
    send_str(MODE_TGT, "r");
    send_str(MODE_ROOT, "/q", 1'b0);
    send_str(MODE_DIR, "/q");
    send_str(MODE_DIR, "/x");
    send_str(MODE_TGT, "s");
  endtask

  task automatic test_limits();
    string s;
    s = "";
    for (int i = 0; i < ROOT_SEGMENTS; i++) s = {s, "/a"};
    send_triple(s, "", "b");
    send_triple({s, "/a"}, "", "b");
    send_triple(s.substr(0, s.len() - 3), s, "b");
    s = "";
    for (int i = 0; i < JOINED_SEGMENTS - 1; i++) s = {s, "/a"};
    send_triple("/a", s, "b");
  endtask

  function automatic string rand_path(int nseg);
    string s, pieces[7];
    pieces = '{"a", "b", "ab", ".", "..", "", "a.b"};
    s = $urandom_range(0, 1) ? "/" : "";
    for (int i = 0; i < nseg; i++) begin
      s = {s, pieces[$urandom_range(0, 6)]};
      if (i < nseg - 1 || $urandom_range(0, 3) == 0) s = {s, "/"};
    end
    return s;
  endfunction

  task automatic test_random();
    string r, d, t;
    while (items_sent < 2000) begin
      if (items_sent > 1700) idling_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        send_byte(MODE_TGT, CH_NUL);
      end else begin
        r = rand_path(int'($urandom_range(0, 4)));
        d = $urandom_range(0, 3) != 0 ? {r, rand_path(int'($urandom_range(0, 2)))}
                                      : rand_path(int'($urandom_range(0, 5)));
        t = rand_path(int'($urandom_range(0, 4)));
        if ($urandom_range(0, 5) == 0) t = {t, string'(8'($urandom_range(1, 255)))};
        send_str(MODE_ROOT, r, $urandom_range(0, 7) != 0);
        send_str(MODE_DIR, d, $urandom_range(0, 7) != 0);
        send_str(MODE_TGT, t);
      end
    end
  endtask

  initial begin
    clear_paths();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_basic();
    test_odd_order();
    test_limits();
    test_random();
    start = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
